// ----- src/pgc_pkg.sv -----
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared types, constants and character tables of the glitch character
// generator.
// ----------------------------------------------------------------------------
package pgc_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // configuration bus
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_SEED      = 2'd1;
    localparam logic [1:0] REG_INTENSITY = 2'd2;

    // command codes
    localparam logic [2:0] CMD_TERRAIN = 3'd0;
    localparam logic [2:0] CMD_SHAPE   = 3'd1;
    localparam logic [2:0] CMD_NOISE   = 3'd2;
    localparam logic [2:0] CMD_CASCADE = 3'd3;
    localparam logic [2:0] CMD_MATRIX  = 3'd4;

    // hash constants
    localparam logic [31:0] HASH_MUL_X = 32'd73;
    localparam logic [31:0] HASH_MUL_Y = 32'd37;
    localparam logic [31:0] HASH_MUL_F = 32'd17;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;

    // rate modulus and thresholds
    localparam logic [31:0] RATE_MOD      = 32'd10000;
    localparam logic [16:0] TERRAIN_BASE  = 17'd1000;
    localparam logic [16:0] SHAPE_BASE    = 17'd500;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;

    // floor(2^32 / n) reciprocals, quotient estimate is exact or one low
    localparam logic [63:0] TWO_POW_32   = 64'h1_0000_0000;
    localparam logic [31:0] RECIP_10     = 32'(TWO_POW_32 / 64'd10);
    localparam logic [31:0] RECIP_RATE   = 32'(TWO_POW_32 / 64'd10000);

    // character tables
    localparam int TERRAIN_LEN = 19;
    localparam int SHAPE_LEN   = 21;
    localparam int NOISE_LEN   = 40;
    localparam int MATRIX_LEN  = 47;
    localparam logic [8*TERRAIN_LEN-1:0] TERRAIN_STR = "#=-%*+~^|\\/<>[]{}()";
    localparam logic [8*SHAPE_LEN-1:0]   SHAPE_STR   = "@#*+=-|\\/<>^~`'\".:;!?";
    localparam logic [8*NOISE_LEN-1:0]   NOISE_STR   =
        "01234567890123456789abcdefABCDEF!@#$%^&*";
    localparam logic [8*MATRIX_LEN-1:0]  MATRIX_STR  =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*+-=";

    localparam logic [31:0] RECIP_TERRAIN = 32'(TWO_POW_32 / 64'(TERRAIN_LEN));
    localparam logic [31:0] RECIP_SHAPE   = 32'(TWO_POW_32 / 64'(SHAPE_LEN));
    localparam logic [31:0] RECIP_NOISE   = 32'(TWO_POW_32 / 64'(NOISE_LEN));
    localparam logic [31:0] RECIP_MATRIX  = 32'(TWO_POW_32 / 64'(MATRIX_LEN));

    // configuration registers
    typedef struct packed {
        logic        enabled;
        logic [31:0] seed;
        logic [9:0]  intensity;
    } t_cfg;

    // item leaving the hash pipeline
    typedef struct packed {
        logic        valid;
        logic [2:0]  cmd;
        logic [7:0]  orig;
        logic [31:0] hash;
    } t_hash_item;

    // table length for a command
    function automatic logic [5:0] tab_len(input logic [2:0] cmd);
        logic [5:0] len;
        unique case (cmd)
            CMD_TERRAIN: len = 6'(TERRAIN_LEN);
            CMD_SHAPE:   len = 6'(SHAPE_LEN);
            CMD_NOISE:   len = 6'(NOISE_LEN);
            default:     len = 6'(MATRIX_LEN);
        endcase
        return len;
    endfunction

    // table reciprocal for a command
    function automatic logic [31:0] tab_recip(input logic [2:0] cmd);
        logic [31:0] m;
        unique case (cmd)
            CMD_TERRAIN: m = RECIP_TERRAIN;
            CMD_SHAPE:   m = RECIP_SHAPE;
            CMD_NOISE:   m = RECIP_NOISE;
            default:     m = RECIP_MATRIX;
        endcase
        return m;
    endfunction

    // table lookups, first character in the top byte
    function automatic logic [7:0] terrain_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < TERRAIN_LEN; i++) begin
            if (idx == 6'(i)) c = TERRAIN_STR[8*(TERRAIN_LEN-1-i) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] shape_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < SHAPE_LEN; i++) begin
            if (idx == 6'(i)) c = SHAPE_STR[8*(SHAPE_LEN-1-i) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < NOISE_LEN; i++) begin
            if (idx == 6'(i)) c = NOISE_STR[8*(NOISE_LEN-1-i) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] matrix_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < MATRIX_LEN; i++) begin
            if (idx == 6'(i)) c = MATRIX_STR[8*(MATRIX_LEN-1-i) +: 8];
        end
        return c;
    endfunction

endpackage

// ----- src/pgc_regs.sv -----
// ----------------------------------------------------------------------------
// pgc_regs
// APB-style register file holding enable, seed and intensity.
// ----------------------------------------------------------------------------
module pgc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [pgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [pgc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output pgc_pkg::t_cfg                 o_cfg
);
    import pgc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLED:   n_cfg.enabled   = pwdata[0];
                REG_SEED:      n_cfg.seed      = pwdata;
                REG_INTENSITY: n_cfg.intensity = pwdata[9:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_ENABLED:   prdata = {31'd0, r_cfg.enabled};
            REG_SEED:      prdata = r_cfg.seed;
            REG_INTENSITY: prdata = {22'd0, r_cfg.intensity};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/pgc_hash.sv -----
// ----------------------------------------------------------------------------
// pgc_hash
// Four-stage position hash: frame divide, operand select, sum, LCG step.
// ----------------------------------------------------------------------------
module pgc_hash #(
    parameter int COORD_BITS = pgc_pkg::COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [2:0]             i_cmd,
    input  logic [7:0]             i_orig_char,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    input  logic [31:0]            i_frame_num,
    input  logic [31:0]            i_seed,
    output pgc_pkg::t_hash_item    o_item
);
    import pgc_pkg::*;

    // stage a: capture and frame / 10 quotient estimate
    logic        r_a_valid;
    logic [2:0]  r_a_cmd;
    logic [7:0]  r_a_orig;
    logic [31:0] r_a_x;
    logic [31:0] r_a_y;
    logic [31:0] r_a_f;
    logic [31:0] r_a_q10;
    logic [63:0] n_a_prod;

    assign n_a_prod = 64'(i_frame_num) * 64'(RECIP_10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_cmd  <= i_cmd;
        r_a_orig <= i_orig_char;
        r_a_x    <= 32'(i_pos_x);
        r_a_y    <= 32'(i_pos_y);
        r_a_f    <= i_frame_num;
        r_a_q10  <= n_a_prod[63:32];
    end

    // stage b: quotient correction and hash operand select
    logic        r_b_valid;
    logic [2:0]  r_b_cmd;
    logic [7:0]  r_b_orig;
    logic [31:0] r_b_x;
    logic [31:0] r_b_y;
    logic [31:0] r_b_f;
    logic [31:0] n_b_x;
    logic [31:0] n_b_y;
    logic [31:0] n_b_f;
    logic [31:0] rem10;
    logic [31:0] q10;

    assign rem10 = r_a_f - ({r_a_q10[28:0], 3'b000} + {r_a_q10[30:0], 1'b0});
    assign q10   = (rem10 >= 32'd10) ? r_a_q10 + 32'd1 : r_a_q10;

    always_comb begin
        n_b_x = r_a_x;
        n_b_y = r_a_y;
        n_b_f = r_a_f;
        if (r_a_cmd == CMD_CASCADE) begin
            n_b_x = r_a_x >> 3;
            n_b_y = '0;
            n_b_f = q10;
        end else if (r_a_cmd == CMD_NOISE) begin
            n_b_f = {r_a_f[30:0], 1'b0} + r_a_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_cmd  <= r_a_cmd;
        r_b_orig <= r_a_orig;
        r_b_x    <= n_b_x;
        r_b_y    <= n_b_y;
        r_b_f    <= n_b_f;
    end

    // stage c: weighted position sum and seed mix
    logic        r_c_valid;
    logic [2:0]  r_c_cmd;
    logic [7:0]  r_c_orig;
    logic [31:0] r_c_h0;
    logic [31:0] n_c_h0;

    assign n_c_h0 = (r_b_x * HASH_MUL_X + r_b_y * HASH_MUL_Y + r_b_f * HASH_MUL_F) ^ i_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_cmd  <= r_b_cmd;
        r_c_orig <= r_b_orig;
        r_c_h0   <= n_c_h0;
    end

    // stage d: lcg step
    t_hash_item r_d_item;
    t_hash_item n_d_item;

    always_comb begin
        n_d_item.valid = r_c_valid;
        n_d_item.cmd   = r_c_cmd;
        n_d_item.orig  = r_c_orig;
        n_d_item.hash  = r_c_h0 * LCG_MUL + LCG_ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_item.valid <= 1'b0;
        end else begin
            r_d_item.valid <= n_d_item.valid;
        end
        r_d_item.cmd  <= n_d_item.cmd;
        r_d_item.orig <= n_d_item.orig;
        r_d_item.hash <= n_d_item.hash;
    end

    assign o_item = r_d_item;

endmodule

// ----- src/pgc_select.sv -----
// ----------------------------------------------------------------------------
// pgc_select
// Three-stage rate test and table pick: reciprocal products, remainder
// correction, threshold compare and character output.
// ----------------------------------------------------------------------------
module pgc_select (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pgc_pkg::t_hash_item  i_item,
    input  pgc_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_cascade_hit
);
    import pgc_pkg::*;

    // stage e: quotient estimates for h / 10000 and (h >> 8) / len
    logic        r_e_valid;
    logic [2:0]  r_e_cmd;
    logic [7:0]  r_e_orig;
    logic [31:0] r_e_h;
    logic [18:0] r_e_qr;
    logic [19:0] r_e_qv;
    logic [63:0] n_e_prod_r;
    logic [63:0] n_e_prod_v;

    assign n_e_prod_r = 64'(i_item.hash) * 64'(RECIP_RATE);
    assign n_e_prod_v = 64'(i_item.hash[31:8]) * 64'(tab_recip(i_item.cmd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= i_item.valid;
        end
        r_e_cmd  <= i_item.cmd;
        r_e_orig <= i_item.orig;
        r_e_h    <= i_item.hash;
        r_e_qr   <= n_e_prod_r[50:32];
        r_e_qv   <= n_e_prod_v[51:32];
    end

    // stage f: remainders with one correction step each
    logic        r_f_valid;
    logic [2:0]  r_f_cmd;
    logic [7:0]  r_f_orig;
    logic [13:0] r_f_rate;
    logic [5:0]  r_f_idx;
    logic [31:0] rate_est;
    logic [23:0] idx_est;
    logic [5:0]  len_f;
    logic [13:0] n_f_rate;
    logic [5:0]  n_f_idx;

    assign len_f    = tab_len(r_e_cmd);
    assign rate_est = r_e_h - 32'(r_e_qr) * RATE_MOD;
    assign idx_est  = r_e_h[31:8] - 24'(r_e_qv) * 24'(len_f);
    assign n_f_rate = (rate_est >= RATE_MOD) ? 14'(rate_est - RATE_MOD) : 14'(rate_est);
    assign n_f_idx  = (idx_est >= 24'(len_f)) ? 6'(idx_est - 24'(len_f)) : 6'(idx_est);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_e_valid;
        end
        r_f_cmd  <= r_e_cmd;
        r_f_orig <= r_e_orig;
        r_f_rate <= n_f_rate;
        r_f_idx  <= n_f_idx;
    end

    // stage g: threshold compare and character choice
    logic        r_g_valid;
    logic [7:0]  r_g_char;
    logic        r_g_hit;
    logic [7:0]  n_g_char;
    logic        n_g_hit;
    logic [16:0] rate_ext;
    logic [16:0] inten_ext;

    assign rate_ext  = 17'(r_f_rate);
    assign inten_ext = 17'(i_cfg.intensity);

    always_comb begin
        n_g_char = r_f_orig;
        n_g_hit  = 1'b0;
        unique case (r_f_cmd)
            CMD_TERRAIN: begin
                if (i_cfg.enabled && rate_ext < TERRAIN_BASE + {inten_ext[14:0], 2'b00})
                    n_g_char = terrain_char(r_f_idx);
            end
            CMD_SHAPE: begin
                if (i_cfg.enabled &&
                    rate_ext < SHAPE_BASE + {inten_ext[15:0], 1'b0} + inten_ext)
                    n_g_char = shape_char(r_f_idx);
            end
            CMD_NOISE: begin
                n_g_char = SPACE_CHAR;
                if (i_cfg.enabled && rate_ext < inten_ext)
                    n_g_char = noise_char(r_f_idx);
            end
            CMD_CASCADE: begin
                n_g_char = 8'h00;
                n_g_hit  = i_cfg.enabled && ({rate_ext[14:0], 2'b00} + rate_ext < inten_ext);
            end
            CMD_MATRIX: begin
                n_g_char = matrix_char(r_f_idx);
            end
            default: begin
                n_g_char = r_f_orig;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
        r_g_char <= n_g_char;
        r_g_hit  <= n_g_hit;
    end

    assign o_valid       = r_g_valid;
    assign o_out_char    = r_g_char;
    assign o_cascade_hit = r_g_hit;

endmodule

// ----- src/pixel_glitch_char_generator.sv -----
// ----------------------------------------------------------------------------
// pixel_glitch_char_generator
// Per-cell glitch character generator for a text raster.
//
// Usage: pulse start with a command and a cell (orig char, x, y, frame);
// busy is always low, so a new transaction is taken on every clock.
// Each transaction yields exactly one result: o_done is high for one
// cycle with o_out_char and o_cascade_hit, once the cell has passed the
// seven-stage pipeline (frame divide, operand select, hash sum, lcg
// multiply, reciprocal products, remainder correction, table pick).
// Throughput is one cell per clock. The receiver cannot stall: a result
// is shown once and must be taken. Reset clears the pipeline valid bits
// and all configuration registers (disabled, seed 0, intensity 0); no
// results follow reset until a new transaction is started. Configuration
// is to be written over the APB port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pixel_glitch_char_generator #(
    parameter int COORD_BITS = pgc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_cmd,
    input  logic [7:0]                    i_orig_char,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [31:0]                   i_frame_num,
    // result channel
    output logic                          o_done,
    output logic [7:0]                    o_out_char,
    output logic                          o_cascade_hit,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [pgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [pgc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import pgc_pkg::*;

    t_cfg       cfg;
    t_hash_item hash_item;
    logic       accept;

    // pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    pgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // position hash
    pgc_hash #(
        .COORD_BITS (COORD_BITS)
    ) u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_cmd       (i_cmd),
        .i_orig_char (i_orig_char),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_frame_num (i_frame_num),
        .i_seed      (cfg.seed),
        .o_item      (hash_item)
    );

    // rate test and character pick
    pgc_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (hash_item),
        .i_cfg         (cfg),
        .o_valid       (o_done),
        .o_out_char    (o_out_char),
        .o_cascade_hit (o_cascade_hit)
    );

endmodule
